### hdl/acfe_pkg.sv
// Package for the AC infrared frame encoder: payload word types, frame constants,
// field codes and register indexes. No dependencies.
package acfe_pkg;

    localparam int FRAME_BITS = 28;
    localparam int PULSES     = 2 * FRAME_BITS + 3;
    localparam int CNT_W      = $clog2(PULSES);
    localparam logic [CNT_W-1:0] LAST_PULSE_IDX = CNT_W'(PULSES - 1);

    // Frame field codes
    localparam logic [4:0] STATE_ON_CODE  = 5'd0;
    localparam logic [4:0] STATE_OFF_CODE = 5'd24;
    localparam logic [4:0] TEMP_OFFSET    = 5'd15;
    localparam logic [2:0] FAN_AUTO_CODE  = 3'd5;
    localparam logic [2:0] MODE_MAX       = 3'd4;
    localparam logic [2:0] MODE_COOL      = 3'd0;

    // Configuration register indexes
    localparam logic [2:0] CFG_HDR_MARK  = 3'd0;
    localparam logic [2:0] CFG_HDR_SPACE = 3'd1;
    localparam logic [2:0] CFG_BIT_MARK  = 3'd2;
    localparam logic [2:0] CFG_ONE_SPACE = 3'd3;
    localparam logic [2:0] CFG_ZERO_SPACE = 3'd4;
    localparam logic [2:0] CFG_HDR_BYTE  = 3'd5;

    // Configuration reset values
    localparam logic [15:0] RST_HDR_MARK   = 16'd8000;
    localparam logic [15:0] RST_HDR_SPACE  = 16'd4000;
    localparam logic [15:0] RST_BIT_MARK   = 16'd600;
    localparam logic [15:0] RST_ONE_SPACE  = 16'd1600;
    localparam logic [15:0] RST_ZERO_SPACE = 16'd550;
    localparam logic [7:0]  RST_HDR_BYTE   = 8'd136;

    typedef struct packed {
        logic       power_on;
        logic [2:0] mode_code;
        logic [4:0] temperature_c;
        logic [2:0] fan_speed;
    } t_in_word;

    typedef struct packed {
        logic [15:0] pulse_time;
        logic        is_mark;
        logic        last_pulse;
    } t_out_word;

endpackage

### hdl/ac_ir_frame_encoder_unit.sv
// Top level of the AC infrared frame encoder: config registers, frame shifter and
// pulse output register. Depends on acfe_pkg and acfe_frame_build.
//
// Each accepted setting word produces 59 pulse words: header mark, header space,
// a bit mark plus a one- or zero-space for each of the 28 frame bits (MSB first),
// and a trailing mark flagged with last_pulse. The frame word is built in the
// accept cycle and held in a shift register; one pulse word per cycle then moves
// into the output register while the output side does not stall. The next setting is
// taken in the same cycle that the trailing mark enters the output register, so frames
// run back to back with no gap. Output stalls hold the pulse sequence in place.
// Configuration writes take effect at once and must happen while no frame is
// in flight; writes to indexes 6 and 7 are dropped.
module ac_ir_frame_encoder_unit
    import acfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // setting channel
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    // pulse channel
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_hdr_mark, r_hdr_space, r_bit_mark, r_one_space, r_zero_space;
    logic [7:0]  r_hdr_byte;

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [FRAME_BITS-1:0] r_frame;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic [FRAME_BITS-1:0] w_frame_new;
    logic                  w_adv;
    logic                  w_accept;
    logic                  w_done;
    t_out_word             n_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mark   <= RST_HDR_MARK;
            r_hdr_space  <= RST_HDR_SPACE;
            r_bit_mark   <= RST_BIT_MARK;
            r_one_space  <= RST_ONE_SPACE;
            r_zero_space <= RST_ZERO_SPACE;
            r_hdr_byte   <= RST_HDR_BYTE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HDR_MARK:   r_hdr_mark   <= i_cfg_data;
                CFG_HDR_SPACE:  r_hdr_space  <= i_cfg_data;
                CFG_BIT_MARK:   r_bit_mark   <= i_cfg_data;
                CFG_ONE_SPACE:  r_one_space  <= i_cfg_data;
                CFG_ZERO_SPACE: r_zero_space <= i_cfg_data;
                CFG_HDR_BYTE:   r_hdr_byte   <= i_cfg_data[7:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    acfe_frame_build u_build (
        .i_setting     (i_in_data),
        .i_header_byte (r_hdr_byte),
        .o_frame       (w_frame_new)
    );

    // while busy, advance one pulse whenever the output register is free or being drained
    assign w_adv      = r_busy && (!r_out_valid || i_out_ready);
    assign w_done     = w_adv && (r_cnt == LAST_PULSE_IDX);
    assign o_in_ready = !r_busy || w_done;
    assign w_accept   = i_in_valid && o_in_ready;

    // pick the pulse for the current slot; the frame MSB is the bit in flight
    always_comb begin
        n_out.last_pulse = 1'b0;
        if (r_cnt == '0) begin
            n_out.pulse_time = r_hdr_mark;
            n_out.is_mark    = 1'b1;
        end else if (r_cnt == CNT_W'(1)) begin
            n_out.pulse_time = r_hdr_space;
            n_out.is_mark    = 1'b0;
        end else if (r_cnt == LAST_PULSE_IDX) begin
            n_out.pulse_time = r_bit_mark;
            n_out.is_mark    = 1'b1;
            n_out.last_pulse = 1'b1;
        end else if (!r_cnt[0]) begin
            n_out.pulse_time = r_bit_mark;
            n_out.is_mark    = 1'b1;
        end else begin
            n_out.pulse_time = r_frame[FRAME_BITS-1] ? r_one_space : r_zero_space;
            n_out.is_mark    = 1'b0;
        end
    end

    // sequencer and frame shifter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_adv) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame <= w_frame_new;
        end else if (w_adv && r_cnt[0] && (r_cnt != CNT_W'(1))) begin
            // shift after each bit space
            r_frame <= {r_frame[FRAME_BITS-2:0], 1'b0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // idle sequencer always waits at the first slot
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0))
        else $error("pulse counter not parked while idle");

    // a new setting is only taken when idle or on the trailing mark
    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && r_busy) |-> (r_cnt == LAST_PULSE_IDX))
        else $error("setting taken in the middle of a frame");

    // accepted setting starts a frame at the header mark
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_busy && (r_cnt == '0)))
        else $error("frame did not start after accept");

    // the trailing pulse is always a mark
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_pulse) |-> o_out_data.is_mark)
        else $error("last pulse is not a mark");

endmodule

### hdl/acfe_frame_build.sv
// Builds the 28-bit frame word (header, state, mode, temp, jet, fan, checksum)
// from one setting. Depends on acfe_pkg.
module acfe_frame_build
    import acfe_pkg::*;
(
    input  t_in_word              i_setting,
    input  logic [7:0]            i_header_byte,
    output logic [FRAME_BITS-1:0] o_frame
);

    logic [4:0]  w_state;
    logic [2:0]  w_mode;
    logic [3:0]  w_temp;
    logic [2:0]  w_fan;
    logic [2:0]  w_fan_map;
    logic [4:0]  w_temp_diff;
    logic [23:0] w_body;
    logic [3:0]  w_sum;

    always_comb begin
        case (i_setting.fan_speed)
            3'd1:    w_fan_map = 3'd1;
            3'd2:    w_fan_map = 3'd0;
            3'd3:    w_fan_map = 3'd2;
            3'd4:    w_fan_map = 3'd4;
            default: w_fan_map = FAN_AUTO_CODE;
        endcase
    end

    assign w_temp_diff = i_setting.temperature_c - TEMP_OFFSET;

    always_comb begin
        if (i_setting.power_on) begin
            w_state = STATE_ON_CODE;
            w_mode  = (i_setting.mode_code <= MODE_MAX) ? i_setting.mode_code : MODE_COOL;
            w_temp  = w_temp_diff[3:0];
            w_fan   = w_fan_map;
        end else begin
            // unit off: fixed state, mode, temp and fan codes
            w_state = STATE_OFF_CODE;
            w_mode  = MODE_COOL;
            w_temp  = 4'd0;
            w_fan   = FAN_AUTO_CODE;
        end
    end

    // jet bit sits at bit 3 and is always zero
    assign w_body = {i_header_byte, w_state, w_mode, w_temp, 1'b0, w_fan};

    // nibble sum, wrapped to four bits
    assign w_sum = w_body[23:20] + w_body[19:16] + w_body[15:12]
                 + w_body[11:8]  + w_body[7:4]   + w_body[3:0];

    assign o_frame = {w_body, w_sum};

endmodule

### verif/tb_ac_ir_frame_encoder_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for ac_ir_frame_encoder_unit: setting words in, 59 pulse words out.
// Depends on acfe_pkg and the encoder RTL; checks every pulse word against a local frame model.
module tb_ac_ir_frame_encoder_unit;
    import acfe_pkg::*;

    // Mode codes the package does not name
    localparam logic [2:0] MODE_DRY  = 3'd1;
    localparam logic [2:0] MODE_FAN  = 3'd2;
    localparam logic [2:0] MODE_AUTO = 3'd3;
    localparam logic [2:0] MODE_HEAT = MODE_MAX;

    // Fan codes sent for explicit speeds 1..4
    localparam logic [2:0] FAN_CODE_1 = 3'd1;
    localparam logic [2:0] FAN_CODE_2 = 3'd0;
    localparam logic [2:0] FAN_CODE_3 = 3'd2;
    localparam logic [2:0] FAN_CODE_4 = 3'd4;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int DIR_ROWS        = 20;

    // One directed row: the setting, whether the frame is typed in, and that frame.
    typedef struct packed {
        t_in_word    setting;
        logic        typed;
        logic [27:0] frame;
    } t_dir_row;

    // The first row sits in the top slice, so the table is walked from the top down.
    // Typed frames assume the reset register values (header byte 0x88).
    localparam t_dir_row [DIR_ROWS-1:0] DIR_TABLE = {
        // unit off, then off with every other field at its top: both give the fixed off frame
        {1'b0, MODE_COOL, 5'd15, 3'd0, 1'b1, 28'h88C0051},
        {1'b0, 3'd7,      5'd31, 3'd7, 1'b1, 28'h88C0051},
        // lowest legal temperature, fan 0 falls to auto
        {1'b1, MODE_COOL, 5'd15, 3'd0, 1'b1, 28'h8800055},
        // heating at the top temperature, fan 4
        {1'b1, MODE_HEAT, 5'd30, 3'd4, 1'b1, 28'h8804F47},
        // unknown mode is sent as cooling
        {1'b1, 3'd7,      5'd15, 3'd1, 1'b1, 28'h8800011},
        {1'b1, MODE_AUTO, 5'd20, 3'd2, 1'b1, 28'h8803508},
        // temperatures below and above the range wrap modulo 16
        {1'b1, MODE_DRY,  5'd0,  3'd3, 1'b1, 28'h8801124},
        {1'b1, MODE_FAN,  5'd31, 3'd6, 1'b1, 28'h8802057},
        // the rest go through the predictor
        {1'b1, 3'd5,      5'd14, 3'd5, 1'b0, 28'h0},
        {1'b1, 3'd6,      5'd16, 3'd7, 1'b0, 28'h0},
        {1'b1, MODE_HEAT, 5'd29, 3'd0, 1'b0, 28'h0},
        {1'b1, MODE_COOL, 5'd22, 3'd4, 1'b0, 28'h0},
        {1'b1, MODE_DRY,  5'd25, 3'd1, 1'b0, 28'h0},
        {1'b1, MODE_FAN,  5'd18, 3'd2, 1'b0, 28'h0},
        {1'b1, MODE_AUTO, 5'd27, 3'd3, 1'b0, 28'h0},
        {1'b0, MODE_HEAT, 5'd30, 3'd4, 1'b0, 28'h0},
        {1'b1, 3'd7,      5'd31, 3'd7, 1'b0, 28'h0},
        {1'b0, 3'd0,      5'd0,  3'd0, 1'b0, 28'h0},
        {1'b1, 3'd0,      5'd0,  3'd0, 1'b0, 28'h0},
        {1'b1, 3'd5,      5'd15, 3'd6, 1'b0, 28'h0}
    };

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_word    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_idx   = '0;
    logic [15:0] cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_word   o_out_data;

    // Local copy of the timing and signature registers, kept in step with every write
    logic [15:0] hdr_mark_t   = RST_HDR_MARK;
    logic [15:0] hdr_space_t  = RST_HDR_SPACE;
    logic [15:0] bit_mark_t   = RST_BIT_MARK;
    logic [15:0] one_space_t  = RST_ONE_SPACE;
    logic [15:0] zero_space_t = RST_ZERO_SPACE;
    logic [7:0]  hdr_byte_v   = RST_HDR_BYTE;

    t_out_word pending_pulses [$];
    int        mismatches    = 0;
    int        send_idle_pct = 15;
    int        recv_idle_pct = 70;

    ac_ir_frame_encoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Build the 28-bit frame for one setting from the current register copy.
    function automatic logic [27:0] encode_frame(input t_in_word s);
        logic [4:0]  state;
        logic [2:0]  mode;
        logic [4:0]  temp_diff;
        logic [2:0]  fan;
        logic [23:0] body;
        logic [3:0]  sum;
        if (s.power_on) begin
            state     = STATE_ON_CODE;
            mode      = (s.mode_code <= MODE_MAX) ? s.mode_code : MODE_COOL;
            temp_diff = s.temperature_c - TEMP_OFFSET;
            case (s.fan_speed)
                3'd1:    fan = FAN_CODE_1;
                3'd2:    fan = FAN_CODE_2;
                3'd3:    fan = FAN_CODE_3;
                3'd4:    fan = FAN_CODE_4;
                default: fan = FAN_AUTO_CODE;
            endcase
        end else begin
            // off: everything but the state code is forced
            state     = STATE_OFF_CODE;
            mode      = MODE_COOL;
            temp_diff = '0;
            fan       = FAN_AUTO_CODE;
        end
        // jet bit is always zero
        body = {hdr_byte_v, state, mode, temp_diff[3:0], 1'b0, fan};
        sum  = '0;
        for (int n = 0; n < 6; n++) sum += body[4*n +: 4];
        return {body, sum};
    endfunction

    // Turn a frame into its 59 pulse words and queue them.
    function automatic void queue_frame_pulses(input logic [27:0] frame);
        pending_pulses.push_back({hdr_mark_t, 1'b1, 1'b0});
        pending_pulses.push_back({hdr_space_t, 1'b0, 1'b0});
        for (int b = FRAME_BITS - 1; b >= 0; b--) begin
            pending_pulses.push_back({bit_mark_t, 1'b1, 1'b0});
            pending_pulses.push_back({frame[b] ? one_space_t : zero_space_t, 1'b0, 1'b0});
        end
        pending_pulses.push_back({bit_mark_t, 1'b1, 1'b1});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one setting word, idling first at the current rate, and hold it until taken.
    // The frame is queued at the edge that takes the word.
    task automatic send_setting(input t_in_word s, input logic [27:0] frame);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        queue_frame_pulses(frame);
    endtask

    // Hold until every queued pulse has come out, then let the pipeline settle.
    task automatic wait_drained();
        while (pending_pulses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all eight indexes; 6 and 7 get junk that the block must drop.
    task automatic load_config(input logic [15:0] hm, input logic [15:0] hs,
                               input logic [15:0] bm, input logic [15:0] os,
                               input logic [15:0] zs, input logic [15:0] hb);
        logic [15:0] vals [8];
        logic [2:0]  idx;
        vals[0] = hm;
        vals[1] = hs;
        vals[2] = bm;
        vals[3] = os;
        vals[4] = zs;
        vals[5] = hb;
        vals[6] = 16'($urandom);
        vals[7] = 16'($urandom);
        for (int k = 0; k < 8; k++) begin
            idx = 3'(k);
            cfg_we   <= 1'b1;
            cfg_idx  <= idx;
            cfg_data <= vals[k];
            @(posedge i_clk);
            case (idx)
                CFG_HDR_MARK:   hdr_mark_t   = vals[k];
                CFG_HDR_SPACE:  hdr_space_t  = vals[k];
                CFG_BIT_MARK:   bit_mark_t   = vals[k];
                CFG_ONE_SPACE:  one_space_t  = vals[k];
                CFG_ZERO_SPACE: zero_space_t = vals[k];
                CFG_HDR_BYTE:   hdr_byte_v   = vals[k][7:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: drop ready at the current idle rate, fresh draw every cycle.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each pulse word taken against the oldest queued one, field by field.
    always @(posedge i_clk) begin : pulse_check
        t_out_word want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_pulses.size() == 0) begin
                report_mismatch($sformatf("pulse word with none pending (time %0d mark %0b)",
                                          o_out_data.pulse_time, o_out_data.is_mark));
            end else begin
                want = pending_pulses.pop_front();
                if (o_out_data.pulse_time !== want.pulse_time)
                    report_mismatch($sformatf("pulse_time got %0d want %0d",
                                              o_out_data.pulse_time, want.pulse_time));
                if (o_out_data.is_mark !== want.is_mark)
                    report_mismatch($sformatf("is_mark got %0b want %0b",
                                              o_out_data.is_mark, want.is_mark));
                if (o_out_data.last_pulse !== want.last_pulse)
                    report_mismatch($sformatf("last_pulse got %0b want %0b",
                                              o_out_data.last_pulse, want.last_pulse));
            end
        end
    end

    initial begin
        t_dir_row row;
        t_in_word s;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run on the reset register values.
        for (int i = DIR_ROWS - 1; i >= 0; i--) begin
            row = DIR_TABLE[i];
            send_setting(row.setting, row.typed ? row.frame : encode_frame(row.setting));
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Registers change only with the encoder idle.
            in_valid <= 1'b0;
            wait_drained();
            case (phase)
                0: load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                4: load_config(RST_HDR_MARK, RST_HDR_SPACE, RST_BIT_MARK, RST_ONE_SPACE,
                               RST_ZERO_SPACE, {8'($urandom), RST_HDR_BYTE});
                default: load_config(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom));
            endcase

            // Sender light and receiver heavy, then swapped, then no idling at all.
            if (phase < 2) begin
                send_idle_pct = 15;
                recv_idle_pct = 70;
            end else if (phase < 4) begin
                send_idle_pct = 70;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Mostly in-range settings, with a share of off, unknown modes and
            // out-of-range temperatures.
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                s.power_on      = ($urandom_range(99) < 80);
                s.mode_code     = ($urandom_range(99) < 75) ? 3'($urandom_range(4, 0))
                                                            : 3'($urandom_range(7, 0));
                s.temperature_c = ($urandom_range(99) < 75) ? 5'($urandom_range(30, 15))
                                                            : 5'($urandom_range(31, 0));
                s.fan_speed     = 3'($urandom_range(7, 0));
                send_setting(s, encode_frame(s));
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        // Give a stray extra frame time to show up.
        repeat (2 * PULSES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Stop well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### files.f
hdl/acfe_pkg.sv
hdl/acfe_frame_build.sv
hdl/ac_ir_frame_encoder_unit.sv
verif/tb_ac_ir_frame_encoder_unit.sv
